// ===== rtl/scba_pkg.sv =====
// Shared types and codes for the size-class block allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package scba_pkg;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam int         CFG_IDX_W        = 1;
	localparam logic       CFG_REGION_START = 1'b0;
	localparam logic       CFG_REGION_PAGES = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO      = 3'd1,
		ST_NOMEM     = 3'd2,
		ST_BAD_FREE  = 3'd3,
		ST_TOO_LARGE = 3'd4
	} scba_status_e;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [11:0] request_size;
		logic [31:0] block_address;
		logic        frame_ok;
	} scba_in_t;

	typedef struct packed {
		logic [31:0] result_address;
		logic [11:0] block_bytes;
		logic [2:0]  status;
	} scba_out_t;

	// controller -> datapath
	typedef struct packed {
		logic         capture;
		logic         sel_req;
		logic         sel_larger;
		logic         rd_head;
		logic         pop;
		logic         take_page;
		logic         carve;
		logic         rd_free;
		logic         push_free;
		logic         walk_start;
		logic         walk_step;
		logic         res_we;
		logic         res_query;
		scba_status_e res_code;
		logic         out_load;
	} scba_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] opcode;
		logic       zero;
		logic       too_large;
		logic       cls_nz;
		logic       fp_nz;
		logic       frame_ok;
		logic       larger_found;
		logic       free_ok;
		logic       free_bit;
		logic       count_full;
		logic       carve_last;
		logic       walk_last;
	} scba_stat_t;

endpackage

`default_nettype wire

// ===== rtl/scba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used by the allocator datapath for the block link store.
`default_nettype none

module scba_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 16384
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/scba_ctrl.sv =====
// Sequencer of the size-class block allocator: one-hot state machine that
// drives the datapath through scba_cmd_t and reads scba_stat_t (scba_pkg).
`default_nettype none

module scba_ctrl
	import scba_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  wire         out_ready,
	input  scba_stat_t  stat,
	output scba_cmd_t   cmd
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_DECODE  = 9'b000000010,
		S_CARVE   = 9'b000000100,
		S_POP_RD  = 9'b000001000,
		S_POP     = 9'b000010000,
		S_FREE_RD = 9'b000100000,
		S_WALK_RD = 9'b001000000,
		S_WALK    = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_e;

	state_e state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.res_code = ST_OK;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				case (stat.opcode)
					OP_ALLOC: begin
						if (stat.zero) begin
							cmd.res_we = 1'b1;
							cmd.res_code = ST_ZERO;
						end else if (stat.too_large) begin
							cmd.res_we = 1'b1;
							cmd.res_code = ST_TOO_LARGE;
						end else if (stat.cls_nz) begin
							cmd.sel_req = 1'b1;
							cmd.rd_head = 1'b1;
							state_d = S_POP;
						end else if (stat.fp_nz) begin
							if (stat.frame_ok) begin
								cmd.sel_req = 1'b1;
								cmd.take_page = 1'b1;
								state_d = S_CARVE;
							end else begin
								cmd.res_we = 1'b1;
								cmd.res_code = ST_NOMEM;
							end
						end else if (stat.larger_found) begin
							cmd.sel_larger = 1'b1;
							cmd.rd_head = 1'b1;
							state_d = S_POP;
						end else begin
							cmd.res_we = 1'b1;
							cmd.res_code = ST_NOMEM;
						end
					end
					OP_FREE: begin
						if (stat.free_ok) begin
							cmd.rd_free = 1'b1;
							state_d = S_FREE_RD;
						end else begin
							cmd.res_we = 1'b1;
							cmd.res_code = ST_BAD_FREE;
						end
					end
					OP_QUERY: begin
						cmd.res_we = 1'b1;
						cmd.res_query = 1'b1;
					end
					default: begin
						cmd.res_we = 1'b1;
					end
				endcase
			end
			S_CARVE: begin
				cmd.carve = 1'b1;
				if (stat.carve_last) begin
					state_d = S_POP_RD;
				end
			end
			S_POP_RD: begin
				cmd.rd_head = 1'b1;
				state_d = S_POP;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_DONE;
			end
			S_FREE_RD: begin
				if (stat.free_bit) begin
					cmd.res_we = 1'b1;
					cmd.res_code = ST_BAD_FREE;
					state_d = S_DONE;
				end else begin
					cmd.push_free = 1'b1;
					if (stat.count_full) begin
						state_d = S_WALK_RD;
					end else begin
						cmd.res_we = 1'b1;
						state_d = S_DONE;
					end
				end
			end
			S_WALK_RD: begin
				cmd.walk_start = 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_last) begin
					cmd.res_we = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// wait for the output register to drain
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/scba_dp.sv =====
// Datapath of the size-class block allocator: page table, free-page chain,
// class list heads and lengths, block link RAM (scba_ram), result registers.
`default_nettype none

module scba_dp
	import scba_pkg::*;
#(
	parameter int PAGE_COUNT      = 32,
	parameter int PAGE_BYTES      = 4096,
	parameter int MIN_BLOCK_BYTES = 8,
	parameter int MAX_BLOCK_BYTES = 2048
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  scba_in_t             in_data,
	output scba_out_t            out_data,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [31:0]           cfg_wdata,
	input  scba_cmd_t            cmd,
	output scba_stat_t           stat
);

	localparam int LOG_MIN   = $clog2(MIN_BLOCK_BYTES);
	localparam int LOG_MAX   = $clog2(MAX_BLOCK_BYTES);
	localparam int LOG_PB    = $clog2(PAGE_BYTES);
	localparam int GPP       = PAGE_BYTES / MIN_BLOCK_BYTES;
	localparam int LOG_GPP   = LOG_PB - LOG_MIN;
	localparam int PAGE_IW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int GRANULES  = PAGE_COUNT * GPP;
	localparam int G_W       = PAGE_IW + LOG_GPP;
	localparam int NCLS_RAW  = LOG_MAX - LOG_MIN + 1;
	localparam int NCLS      = (NCLS_RAW > 16) ? 16 : NCLS_RAW;
	localparam int CLS_W     = (NCLS > 1) ? $clog2(NCLS) : 1;
	localparam int PC_W      = $clog2(NCLS + 1);
	localparam int LEN_W     = $clog2(GRANULES + 1);
	localparam int CNT_W     = $clog2(GPP + 1);
	localparam int FPL_W     = $clog2(PAGE_COUNT + 1);
	localparam int CV_W      = LOG_GPP + 1;
	localparam int RESET_LIVE = (PAGE_COUNT < 32) ? PAGE_COUNT : 32;

	// configuration
	logic [31:0] region_start_q;
	logic [5:0]  region_pages_q;

	// allocator state
	logic [PC_W-1:0]    page_class_q [PAGE_COUNT];
	logic [CNT_W-1:0]   page_cnt_q   [PAGE_COUNT];
	logic [PAGE_IW-1:0] fp_next_q    [PAGE_COUNT];
	logic [PAGE_IW-1:0] fp_head_q;
	logic [FPL_W-1:0]   fp_len_q;
	logic [G_W-1:0]     class_head_q [NCLS];
	logic [LEN_W-1:0]   class_len_q  [NCLS];

	// per-item working registers
	scba_in_t           item_q;
	logic [CLS_W-1:0]   sel_q;
	logic [PAGE_IW-1:0] page_q;
	logic [G_W-1:0]     gran_q;
	logic [CV_W-1:0]    carve_q;
	logic [G_W-1:0]     cur_q;
	logic [G_W-1:0]     prev_q;
	logic               have_prev_q;
	logic [LEN_W-1:0]   k_q;
	logic [LEN_W-1:0]   kept_q;

	logic [31:0] res_addr_q;
	logic [11:0] res_bytes_q;
	logic [2:0]  res_status_q;
	scba_out_t   out_q;

	// link RAM: {free flag, next granule}
	logic           ram_we;
	logic [G_W-1:0] ram_waddr;
	logic [G_W:0]   ram_wdata;
	logic [G_W-1:0] ram_raddr;
	logic [G_W:0]   ram_rdata;

	scba_ram #(
		.WIDTH (G_W + 1),
		.DEPTH (GRANULES)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// request decode
	logic [11:0]        sz_m1;
	logic [CLS_W-1:0]   req_c;
	logic               too_large;
	logic [5:0]         live;
	logic [31:0]        off;
	logic [31:0]        off_page;
	logic               in_region;
	logic [PAGE_IW-1:0] pf;
	logic [PC_W-1:0]    pc;
	logic [CLS_W-1:0]   fc;
	logic [31:0]        amask;
	logic [G_W-1:0]     g_dec;
	logic [11:0]        q_bytes;
	logic               larger_found;
	logic [CLS_W-1:0]   larger_idx;
	logic [CLS_W-1:0]   head_cls;

	always_comb begin
		int lg;
		int lgc;
		lg = 0;
		sz_m1 = item_q.request_size - 12'd1;
		for (int i = 0; i < 12; i++) begin
			if (sz_m1[i]) begin
				lg = i + 1;
			end
		end
		lgc = (lg < LOG_MIN) ? LOG_MIN : lg;
		too_large = (32'(item_q.request_size) > 32'(MAX_BLOCK_BYTES)) || (lgc > LOG_PB)
			|| ((lgc - LOG_MIN) >= NCLS);
		req_c = CLS_W'(lgc - LOG_MIN);
	end

	always_comb begin
		larger_found = 1'b0;
		larger_idx = '0;
		for (int i = 0; i < NCLS; i++) begin
			if (!larger_found && (CLS_W'(i) > req_c) && (class_len_q[i] != '0)) begin
				larger_found = 1'b1;
				larger_idx = CLS_W'(i);
			end
		end
	end

	assign live = (32'(region_pages_q) > 32'(PAGE_COUNT)) ? 6'(PAGE_COUNT) : region_pages_q;
	assign off = item_q.block_address - region_start_q;
	assign off_page = off >> LOG_PB;
	assign in_region = off_page < 32'(live);
	assign pf = off_page[PAGE_IW-1:0];
	assign pc = page_class_q[pf];
	assign fc = CLS_W'(pc - PC_W'(1));
	assign amask = (32'(MIN_BLOCK_BYTES) << fc) - 32'd1;
	assign g_dec = {pf, off[LOG_PB-1:LOG_MIN]};
	assign q_bytes = (in_region && pc != '0) ? 12'(32'(MIN_BLOCK_BYTES) << fc) : 12'd0;

	assign head_cls = cmd.sel_req ? req_c : (cmd.sel_larger ? larger_idx : sel_q);

	// carve, pop, push and walk helpers
	logic [CV_W-1:0]    carve_step;
	logic [CV_W-1:0]    carve_nx;
	logic [G_W-1:0]     carve_g;
	logic [G_W-1:0]     pop_g;
	logic [PAGE_IW-1:0] pop_page;
	logic [CNT_W:0]     cnt_inc;
	logic               walk_keep;
	logic [LEN_W:0]     k_inc;
	logic [LEN_W-1:0]   kept_nx;

	assign carve_step = CV_W'(1) << sel_q;
	assign carve_nx = carve_q + carve_step;
	assign carve_g = {page_q, carve_q[LOG_GPP-1:0]};
	assign pop_g = class_head_q[sel_q];
	assign pop_page = pop_g[G_W-1:LOG_GPP];
	assign cnt_inc = {1'b0, page_cnt_q[page_q]} + (CNT_W+1)'(1);
	assign walk_keep = cur_q[G_W-1:LOG_GPP] != page_q;
	assign k_inc = {1'b0, k_q} + (LEN_W+1)'(1);
	assign kept_nx = kept_q + LEN_W'(walk_keep);

	always_comb begin
		stat.opcode = item_q.opcode;
		stat.zero = item_q.request_size == 12'd0;
		stat.too_large = too_large;
		stat.cls_nz = class_len_q[req_c] != '0;
		stat.fp_nz = fp_len_q != '0;
		stat.frame_ok = item_q.frame_ok;
		stat.larger_found = larger_found;
		stat.free_ok = in_region && (pc != '0) && ((off & amask) == 32'd0);
		stat.free_bit = ram_rdata[G_W];
		stat.count_full = cnt_inc == (CNT_W+1)'(GPP >> sel_q);
		stat.carve_last = carve_nx == CV_W'(GPP);
		stat.walk_last = k_inc == {1'b0, class_len_q[sel_q]};
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = gran_q;
		ram_wdata = {1'b1, class_head_q[sel_q]};
		if (cmd.carve) begin
			ram_we = 1'b1;
			ram_waddr = carve_g;
		end else if (cmd.pop) begin
			ram_we = 1'b1;
			ram_waddr = pop_g;
			ram_wdata = {1'b0, ram_rdata[G_W-1:0]};
		end else if (cmd.push_free) begin
			ram_we = 1'b1;
		end else if (cmd.walk_step && walk_keep && have_prev_q) begin
			ram_we = 1'b1;
			ram_waddr = prev_q;
			ram_wdata = {1'b1, cur_q};
		end
	end

	always_comb begin
		ram_raddr = class_head_q[head_cls];
		if (cmd.rd_free) begin
			ram_raddr = g_dec;
		end else if (cmd.walk_step) begin
			ram_raddr = ram_rdata[G_W-1:0];
		end
	end

	// rebuild on reset and on every configuration write
	logic [5:0] new_rp;
	logic [5:0] new_live;
	assign new_rp = (cfg_index == CFG_REGION_PAGES) ? cfg_wdata[5:0] : region_pages_q;
	assign new_live = (32'(new_rp) > 32'(PAGE_COUNT)) ? 6'(PAGE_COUNT) : new_rp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= '0;
			region_pages_q <= 6'd32;
			for (int p = 0; p < PAGE_COUNT; p++) begin
				page_class_q[p] <= '0;
				page_cnt_q[p] <= '0;
				fp_next_q[p] <= (p + 1 < RESET_LIVE) ? PAGE_IW'(p + 1) : '0;
			end
			fp_head_q <= '0;
			fp_len_q <= FPL_W'(RESET_LIVE);
			for (int c = 0; c < NCLS; c++) begin
				class_head_q[c] <= '0;
				class_len_q[c] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_REGION_START) begin
				region_start_q <= cfg_wdata;
			end else begin
				region_pages_q <= cfg_wdata[5:0];
			end
			for (int p = 0; p < PAGE_COUNT; p++) begin
				page_class_q[p] <= '0;
				page_cnt_q[p] <= '0;
				fp_next_q[p] <= (32'(p + 1) < 32'(new_live)) ? PAGE_IW'(p + 1) : '0;
			end
			fp_head_q <= '0;
			fp_len_q <= FPL_W'(new_live);
			for (int c = 0; c < NCLS; c++) begin
				class_head_q[c] <= '0;
				class_len_q[c] <= '0;
			end
		end else begin
			if (cmd.take_page) begin
				fp_head_q <= fp_next_q[fp_head_q];
				fp_len_q <= fp_len_q - FPL_W'(1);
				page_class_q[fp_head_q] <= PC_W'(req_c) + PC_W'(1);
				page_cnt_q[fp_head_q] <= CNT_W'(GPP >> req_c);
			end
			if (cmd.carve) begin
				class_head_q[sel_q] <= carve_g;
				class_len_q[sel_q] <= class_len_q[sel_q] + LEN_W'(1);
			end
			if (cmd.pop) begin
				class_head_q[sel_q] <= ram_rdata[G_W-1:0];
				class_len_q[sel_q] <= class_len_q[sel_q] - LEN_W'(1);
				page_cnt_q[pop_page] <= page_cnt_q[pop_page] - CNT_W'(1);
			end
			if (cmd.push_free) begin
				class_head_q[sel_q] <= gran_q;
				class_len_q[sel_q] <= class_len_q[sel_q] + LEN_W'(1);
				page_cnt_q[page_q] <= cnt_inc[CNT_W-1:0];
			end
			if (cmd.walk_step) begin
				if (walk_keep && !have_prev_q) begin
					class_head_q[sel_q] <= cur_q;
				end
				if (stat.walk_last) begin
					// page wholly free: unassign it and requeue at the head
					class_len_q[sel_q] <= kept_nx;
					page_class_q[page_q] <= '0;
					page_cnt_q[page_q] <= '0;
					fp_next_q[page_q] <= fp_head_q;
					fp_head_q <= page_q;
					fp_len_q <= fp_len_q + FPL_W'(1);
				end
			end
		end
	end

	// working registers and results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
		if (cmd.sel_req || cmd.sel_larger) begin
			sel_q <= head_cls;
		end
		if (cmd.take_page) begin
			page_q <= fp_head_q;
			carve_q <= '0;
		end
		if (cmd.carve) begin
			carve_q <= carve_nx;
		end
		if (cmd.rd_free) begin
			sel_q <= fc;
			page_q <= pf;
			gran_q <= g_dec;
		end
		if (cmd.walk_start) begin
			cur_q <= class_head_q[sel_q];
			have_prev_q <= 1'b0;
			k_q <= '0;
			kept_q <= '0;
		end
		if (cmd.walk_step) begin
			cur_q <= ram_rdata[G_W-1:0];
			k_q <= k_inc[LEN_W-1:0];
			kept_q <= kept_nx;
			if (walk_keep) begin
				prev_q <= cur_q;
				have_prev_q <= 1'b1;
			end
		end
		if (cmd.pop) begin
			res_addr_q <= region_start_q + (32'(pop_g) << LOG_MIN);
			res_bytes_q <= '0;
			res_status_q <= ST_OK;
		end else if (cmd.res_we) begin
			res_addr_q <= '0;
			res_bytes_q <= cmd.res_query ? q_bytes : 12'd0;
			res_status_q <= cmd.res_code;
		end
		if (cmd.out_load) begin
			out_q.result_address <= res_addr_q;
			out_q.block_bytes <= res_bytes_q;
			out_q.status <= res_status_q;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== rtl/size_class_block_allocator.sv =====
// Size-class block allocator: power-of-two classes over a region of pages.
// Queries and rejects load their result after decode; a list pop or a free first
// reads the link RAM; a carve first links every block of a fresh page into its
// class list (one block link a cycle), and a free that empties its page then walks
// its class list to unlink the page's blocks. One item in flight: the next is
// accepted in the cycle after the result loads. Reset or a config write rebuilds all state at once.
`default_nettype none

module size_class_block_allocator
	import scba_pkg::*;
#(
	parameter int PAGE_COUNT      = 32,
	parameter int PAGE_BYTES      = 4096,
	parameter int MIN_BLOCK_BYTES = 8,
	parameter int MAX_BLOCK_BYTES = 2048
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  scba_in_t            in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output scba_out_t           out_data,
	input  wire                 cfg_we,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [31:0]          cfg_wdata
);

	scba_cmd_t  cmd;
	scba_stat_t stat;

	scba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	scba_dp #(
		.PAGE_COUNT      (PAGE_COUNT),
		.PAGE_BYTES      (PAGE_BYTES),
		.MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
		.MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

// ===== verif/size_class_block_allocator_tb.sv =====
// Self-checking testbench for the size-class block allocator.
// Needs scba_pkg and size_class_block_allocator; a built-in predictor checks every result.
`default_nettype none

module size_class_block_allocator_tb;
	import scba_pkg::*;

	localparam int PAGES       = 32;
	localparam int PG_BYTES    = 4096;
	localparam int MIN_BYTES   = 8;
	localparam int GRAN_PER_PG = PG_BYTES / MIN_BYTES;
	localparam int GRANULES    = PAGES * GRAN_PER_PG;
	localparam int NUM_CLASSES = 9;
	localparam int IDLE_LIMIT  = 60000;
	localparam int PHASE_ITEMS = 310;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	scba_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	scba_out_t out_data;
	logic      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_REGION_START;
	logic [31:0] cfg_wdata = '0;

	always #2 clk = ~clk;

	size_class_block_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// allocator shadow state
	logic [31:0] region_base;
	logic [5:0]  region_npages;
	logic [3:0]  pg_class [PAGES];
	int          pg_free_cnt [PAGES];
	int          fp_next [PAGES];
	int          fp_head, fp_len;
	int          cls_head [NUM_CLASSES];
	int          cls_len [NUM_CLASSES];
	int          gran_next [GRANULES];
	bit          gran_free [GRANULES];

	scba_in_t    pending_items [$];
	scba_out_t   expected_results [$];
	logic [31:0] live_blocks [$];
	logic [31:0] freed_blocks [$];
	int          errors = 0;
	bit          quiet = 1'b0;
	bit          hold_request = 1'b0;

	function automatic int active_pages();
		return (region_npages < PAGES) ? int'(region_npages) : PAGES;
	endfunction

	function automatic void rebuild_shadow();
		for (int p = 0; p < PAGES; p++) begin
			pg_class[p] = '0;
			pg_free_cnt[p] = 0;
			fp_next[p] = (p + 1 < active_pages()) ? p + 1 : 0;
		end
		for (int c = 0; c < NUM_CLASSES; c++) begin
			cls_head[c] = 0;
			cls_len[c] = 0;
		end
		for (int g = 0; g < GRANULES; g++) begin
			gran_next[g] = 0;
			gran_free[g] = 1'b0;
		end
		fp_head = 0;
		fp_len = active_pages();
		live_blocks.delete();
		freed_blocks.delete();
	endfunction

	function automatic int pop_block(int c);
		int g;
		g = cls_head[c];
		cls_head[c] = gran_next[g];
		cls_len[c]--;
		gran_free[g] = 1'b0;
		pg_free_cnt[g / GRAN_PER_PG]--;
		return g;
	endfunction

	function automatic void push_block(int c, int g);
		gran_next[g] = cls_head[c];
		cls_head[c] = g;
		cls_len[c]++;
		gran_free[g] = 1'b1;
	endfunction

	function automatic scba_out_t predict_allocator(scba_in_t it);
		scba_out_t r;
		logic [31:0] off;
		int bs, c, g, p, n, cur, prev, kept, nx, i;
		bit have_prev;
		r = '0;
		off = it.block_address - region_base;
		case (it.opcode)
			OP_ALLOC: begin
				bs = MIN_BYTES;
				c = 0;
				if (it.request_size == 0) begin
					r.status = ST_ZERO;
					return r;
				end
				while (bs < it.request_size) begin
					bs = bs << 1;
					c++;
				end
				if (c >= NUM_CLASSES || bs > PG_BYTES) begin
					r.status = ST_TOO_LARGE;
					return r;
				end
				if (cls_len[c] > 0) begin
					g = pop_block(c);
				end else if (fp_len > 0) begin
					if (!it.frame_ok) begin
						r.status = ST_NOMEM;
						return r;
					end
					p = fp_head;
					fp_head = fp_next[p];
					fp_len--;
					n = PG_BYTES / bs;
					pg_class[p] = 4'(c + 1);
					pg_free_cnt[p] = n;
					for (i = 0; i < n; i++) push_block(c, p * GRAN_PER_PG + i * (bs / MIN_BYTES));
					g = pop_block(c);
				end else begin
					for (i = c + 1; i < NUM_CLASSES; i++) if (cls_len[i] > 0) break;
					if (i >= NUM_CLASSES) begin
						r.status = ST_NOMEM;
						return r;
					end
					g = pop_block(i);
				end
				r.result_address = region_base + 32'(g * MIN_BYTES);
				r.status = ST_OK;
			end
			OP_FREE: begin
				r.status = ST_BAD_FREE;
				if (off >= 32'(active_pages() * PG_BYTES)) return r;
				p = int'(off / PG_BYTES);
				if (pg_class[p] == 0) return r;
				c = int'(pg_class[p]) - 1;
				bs = MIN_BYTES << c;
				if (off % bs != 0) return r;
				g = int'(off / MIN_BYTES);
				if (gran_free[g]) return r;
				r.status = ST_OK;
				push_block(c, g);
				pg_free_cnt[p]++;
				if (pg_free_cnt[p] != PG_BYTES / bs) return r;
				// page wholly free: unlink its blocks, requeue it at the head
				cur = cls_head[c];
				n = cls_len[c];
				kept = 0;
				prev = 0;
				have_prev = 1'b0;
				for (i = 0; i < n && cur < GRANULES; i++) begin
					nx = gran_next[cur];
					if (cur / GRAN_PER_PG == p) begin
						gran_free[cur] = 1'b0;
					end else begin
						if (have_prev) gran_next[prev] = cur;
						else cls_head[c] = cur;
						prev = cur;
						have_prev = 1'b1;
						kept++;
					end
					cur = nx;
				end
				cls_len[c] = kept;
				pg_class[p] = '0;
				pg_free_cnt[p] = 0;
				fp_next[p] = fp_head;
				fp_head = p;
				fp_len++;
			end
			OP_QUERY: begin
				if (off < 32'(active_pages() * PG_BYTES) && pg_class[off / PG_BYTES] != 0)
					r.block_bytes = 12'(MIN_BYTES << (pg_class[off / PG_BYTES] - 1));
			end
			default: ;
		endcase
		return r;
	endfunction

	// predict at queue time; items run strictly in order
	task automatic queue_item(logic [1:0] op, logic [11:0] size, logic [31:0] addr, logic fok);
		scba_in_t it;
		scba_out_t r;
		it.opcode = op;
		it.request_size = size;
		it.block_address = addr;
		it.frame_ok = fok;
		r = predict_allocator(it);
		if (op == OP_ALLOC && r.status == ST_OK) live_blocks.push_back(r.result_address);
		pending_items.push_back(it);
		expected_results.push_back(r);
	endtask

	task automatic add_random_item();
		int sel, j, c;
		logic [31:0] a;
		logic [11:0] sz;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			c = $urandom_range(0, NUM_CLASSES - 1);
			if ($urandom_range(0, 3) == 0) c = $urandom_range(0, 2);
			else c = $urandom_range(3, NUM_CLASSES - 1);
			sz = (c == 0) ? 12'($urandom_range(1, 8))
				: 12'($urandom_range((MIN_BYTES << (c - 1)) + 1, MIN_BYTES << c));
			queue_item(OP_ALLOC, sz, $urandom, $urandom_range(0, 9) != 0);
		end else if (sel < 80 && live_blocks.size() > 0) begin
			j = $urandom_range(0, live_blocks.size() - 1);
			a = live_blocks[j];
			live_blocks.delete(j);
			freed_blocks.push_back(a);
			if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
			queue_item(OP_FREE, 12'($urandom), a, 1'($urandom));
		end else if (sel < 86) begin
			// broken frees: double, misaligned, outside
			if (freed_blocks.size() > 0 && $urandom_range(0, 1))
				a = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
			else if (live_blocks.size() > 0 && $urandom_range(0, 1))
				a = live_blocks[$urandom_range(0, live_blocks.size() - 1)] + 32'd4;
			else
				a = $urandom;
			queue_item(OP_FREE, 12'($urandom), a, 1'($urandom));
		end else if (sel < 94) begin
			if (live_blocks.size() > 0 && $urandom_range(0, 1))
				a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
			else if ($urandom_range(0, 1))
				a = region_base + 32'($urandom_range(0, PAGES * PG_BYTES + 8191));
			else
				a = $urandom;
			queue_item(OP_QUERY, 12'($urandom), a, 1'($urandom));
		end else if (sel < 96) begin
			queue_item(OP_ALLOC, 12'($urandom_range(2049, 4095)), $urandom, 1'($urandom));
		end else if (sel < 98) begin
			queue_item(OP_ALLOC, 12'd0, $urandom, 1'($urandom));
		end else begin
			queue_item(OP_UNKNOWN, 12'($urandom), $urandom, 1'($urandom));
		end
	endtask

	task automatic write_region(logic [31:0] base, logic [5:0] npages);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_REGION_START;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= CFG_REGION_PAGES;
		cfg_wdata <= {26'd0, npages};
		@(posedge clk);
		cfg_we <= 1'b0;
		region_base = base;
		region_npages = npages;
		rebuild_shadow();
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// driver
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0 && !quiet && $urandom_range(0, 6) == 0) begin
				gap_left <= $urandom_range(0, 13);
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stalls and result checking
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		scba_out_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result %h", out_data);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (out_data.result_address !== exp_r.result_address) begin
						$error("result_address: expected %h, got %h",
							exp_r.result_address, out_data.result_address);
						errors++;
					end
					if (out_data.block_bytes !== exp_r.block_bytes) begin
						$error("block_bytes: expected %0d, got %0d",
							exp_r.block_bytes, out_data.block_bytes);
						errors++;
					end
					if (out_data.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, out_data.status);
						errors++;
					end
				end
			end
			if (hold_request && !long_hold_done) begin
				// hold off long enough for the input side to back up
				long_hold_done <= 1'b1;
				hold_left <= 300;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				hold_left <= $urandom_range(0, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on stalled progress
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] bases [6];
		logic [5:0]  sizes [6];
		region_base = '0;
		region_npages = 6'd32;
		rebuild_shadow();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rejects, null address, every class, frees and queries
		queue_item(OP_ALLOC, 12'd0, 32'hFFFF_FFFF, 1'b1);
		queue_item(OP_ALLOC, 12'd2049, '0, 1'b1);
		queue_item(OP_ALLOC, 12'd4095, '0, 1'b1);
		queue_item(OP_ALLOC, 12'd2048, '0, 1'b0);
		queue_item(OP_ALLOC, 12'd2048, '0, 1'b1);
		queue_item(OP_ALLOC, 12'd2048, '0, 1'b1);
		queue_item(OP_QUERY, '0, 32'd0, 1'b0);
		queue_item(OP_FREE, '0, 32'd0, 1'b0);
		queue_item(OP_FREE, '0, 32'd0, 1'b0);
		queue_item(OP_FREE, '0, 32'd2048, 1'b0);
		for (int c = 0; c < NUM_CLASSES; c++) queue_item(OP_ALLOC, 12'(MIN_BYTES << c), '0, 1'b1);
		queue_item(OP_ALLOC, 12'd1, '0, 1'b1);
		queue_item(OP_QUERY, '0, 32'h0002_0000, 1'b1);
		queue_item(OP_FREE, '0, 32'd4, 1'b1);
		queue_item(OP_UNKNOWN, 12'hFFF, 32'hFFFF_FFFF, 1'b1);
		drain();

		bases[0] = 32'h0000_0000; sizes[0] = 6'd32;
		bases[1] = {$urandom_range(0, 32'hF_FFFF), 12'h000}; sizes[1] = 6'd1;
		bases[2] = 32'hFFFF_F000; sizes[2] = 6'd32;
		bases[3] = {$urandom_range(0, 32'hF_FFFF), 12'h000}; sizes[3] = 6'd63;
		bases[4] = {$urandom_range(0, 32'hF_FFFF), 12'h000}; sizes[4] = 6'($urandom_range(2, 31));
		bases[5] = 32'h0000_0000; sizes[5] = 6'd32;
		for (int ph = 0; ph < 6; ph++) begin
			write_region(bases[ph], sizes[ph]);
			for (int k = 0; k < PHASE_ITEMS; k++) add_random_item();
			if (ph == 2) begin
				while (pending_items.size() > PHASE_ITEMS / 2) @(posedge clk);
				hold_request = 1'b1;
			end
			if (ph == 5) begin
				while (pending_items.size() > 120) @(posedge clk);
				quiet = 1'b1;
			end
			drain();
		end

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/scba_pkg.sv
rtl/scba_ram.sv
rtl/scba_ctrl.sv
rtl/scba_dp.sv
rtl/size_class_block_allocator.sv
verif/size_class_block_allocator_tb.sv
